// ----- design/bta_pkg.sv -----
// ----------------------------------------------------------------------------
// Block table allocator package
// Shared types, operation and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int NUM_BLOCKS_DEF  = 1024;
  localparam int BLOCK_BYTES_DEF = 4096;
  localparam int ACTIVE_RESET    = 1024;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOROOM  = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_ACTIVE    = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] size_bytes;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] result_address;
    logic        moved;
    logic [10:0] used_count;
    logic [10:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic next;
    logic first;
    logic taken;
  } mark_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DIVB, S_DECIDE, S_LEN_RD, S_LEN, S_AFTER,
    S_ALLOC, S_FIT_RD, S_FIT, S_TAKE, S_REL, S_TRIM, S_GROW_RD, S_GROW,
    S_GROW_WR, S_LINK, S_OUT
  } state_t;

endpackage

// ----- design/bta_div.sv -----
// ----------------------------------------------------------------------------
// Block table allocator divider
// Division by a fixed power-of-two divisor, done as a right shift.
// ----------------------------------------------------------------------------
module bta_div #(
  parameter int DW      = 64,
  parameter int DIVISOR = 4096
) (
  input  logic [DW-1:0] dividend,
  output logic [DW-1:0] quotient
);

  // The divisor must be a power of two.
  localparam int SH = $clog2(DIVISOR);

  assign quotient = dividend >> SH;

endmodule

// ----- design/block_table_allocator.sv -----
// ----------------------------------------------------------------------------
// Block table allocator
// First-fit allocator over a table of block marks held in one memory.
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (valid/ready) and each one produces
// exactly one response on the out channel. Configuration writes go through
// cfg_we/cfg_index/cfg_data; the user must issue them only while the block
// is idle, and the block does not enforce this. Writing active_blocks clears
// the pool. BLOCK_BYTES must be a power of two. Steps per request: the block
// count is formed at acceptance, then the block index is registered and the
// request is decoded, then the table is walked at one entry per cycle: a
// chain walk of up to the run length, a first-fit scan of up to NUM_BLOCKS
// entries, and a write per entry taken or released. A request is taken only
// in the idle state, so the next one is not accepted until the response of
// the current one has been placed in the output register.
// After reset and after each active_blocks write, a clearing pass over all
// NUM_BLOCKS entries runs while in_ready is low.
// A finished response sits in the output register; the next request is
// taken meanwhile, and its response waits until the earlier transfer is done.
// ----------------------------------------------------------------------------
module block_table_allocator
  import bta_pkg::*;
#(
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int BW = $clog2(BLOCK_BYTES + 1);
  localparam int PW = CW + BW;

  state_t state, state_next;

  logic [63:0] heap_base;
  logic [10:0] active;
  logic [CW-1:0] pool, cfg_pool;

  logic [CW-1:0] ptr, ptr_next, cnt, cnt_next, run, run_next, len, len_next;
  logic [CW-1:0] b, b_next, nc, nc_next, used, used_next, free, free_next;
  logic n_zero, n_zero_next, n_big, n_big_next, outside, outside_next;
  logic [1:0]  op, op_next, st, st_next;
  logic [63:0] addr, addr_next, res, res_next;
  logic moved, moved_next, move, move_next, trim, trim_next;
  mark_t last_mark, last_mark_next, keep_mark, keep_mark_next;
  logic [PW-1:0] prod, prod_next;

  logic [CW-1:0] ptr_inc, run_inc, len_inc, fit_start, b_nc, b_len;
  logic [CW:0]   grow_end;

  mark_t mem [NUM_BLOCKS];
  mark_t rdata, mem_wdata;
  logic  mem_we;
  logic [IW-1:0] raddr, mem_waddr;

  logic [63:0] nblk_q, bidx_q;

  assign pool     = (32'(active) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : CW'(active);
  assign cfg_pool = (32'(cfg_data[10:0]) > NUM_BLOCKS) ? CW'(NUM_BLOCKS)
                                                      : CW'(cfg_data[10:0]);
  assign ptr_inc   = ptr + 1'b1;
  assign run_inc   = run + 1'b1;
  assign len_inc   = len + 1'b1;
  assign fit_start = ptr - run;
  assign b_nc      = b + nc;
  assign b_len     = b + len;
  assign grow_end  = {1'b0, b} + {1'b0, nc};

  assign in_ready = (state == S_IDLE);

  // Block count of the incoming size, rounded up.
  bta_div #(.DW(64), .DIVISOR(BLOCK_BYTES)) u_nblk (
    .dividend (64'(in_data.size_bytes) + 64'(BLOCK_BYTES - 1)),
    .quotient (nblk_q)
  );

  // Block index of the registered address.
  bta_div #(.DW(64), .DIVISOR(BLOCK_BYTES)) u_bidx (
    .dividend (addr - heap_base),
    .quotient (bidx_q)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
      active    <= 11'(ACTIVE_RESET);
    end else if (cfg_we) begin
      if (cfg_index == CFG_HEAP_BASE) begin
        heap_base <= cfg_data;
      end else begin
        active <= cfg_data[10:0];
      end
    end
  end

  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    cnt_next       = cnt;
    run_next       = run;
    len_next       = len;
    b_next         = b;
    nc_next        = nc;
    used_next      = used;
    free_next      = free;
    n_zero_next    = n_zero;
    n_big_next     = n_big;
    outside_next   = outside;
    op_next        = op;
    st_next        = st;
    addr_next      = addr;
    res_next       = res;
    moved_next     = moved;
    move_next      = move;
    trim_next      = trim;
    last_mark_next = last_mark;
    keep_mark_next = keep_mark;
    prod_next      = prod;
    raddr          = ptr_inc[IW-1:0];
    mem_we         = 1'b0;
    mem_waddr      = ptr[IW-1:0];
    mem_wdata      = '0;
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        ptr_next = ptr_inc;
        if (ptr == CW'(NUM_BLOCKS - 1)) begin
          ptr_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_next     = in_data.operation;
          addr_next   = in_data.address;
          st_next     = ST_OK;
          res_next    = '0;
          moved_next  = 1'b0;
          move_next   = 1'b0;
          trim_next   = 1'b0;
          n_zero_next = (nblk_q == '0);
          n_big_next  = nblk_q > 64'(pool);
          nc_next     = nblk_q[CW-1:0];
          state_next  = S_DIVB;
        end
      end
      S_DIVB: begin
        outside_next = (addr < heap_base) || (bidx_q >= 64'(pool));
        b_next       = bidx_q[CW-1:0];
        state_next   = S_DECIDE;
      end
      S_DECIDE: begin
        case (op)
          OP_ALLOC: state_next = S_ALLOC;
          OP_FREE, OP_RESIZE: begin
            if (addr == '0) begin
              state_next = (op == OP_FREE) ? S_OUT : S_ALLOC;
            end else if (outside) begin
              st_next    = ST_OUTSIDE;
              state_next = S_OUT;
            end else begin
              state_next = S_LEN_RD;
            end
          end
          default: state_next = S_OUT;
        endcase
      end
      S_LEN_RD: begin
        raddr      = b[IW-1:0];
        ptr_next   = b;
        len_next   = '0;
        state_next = S_LEN;
      end
      S_LEN: begin
        if (ptr >= pool || !rdata.taken) begin
          state_next = S_AFTER;
        end else begin
          len_next       = len_inc;
          last_mark_next = rdata;
          if (!n_big && len_inc == nc) begin
            keep_mark_next = rdata;
          end
          if (!rdata.next) begin
            state_next = S_AFTER;
          end else begin
            ptr_next = ptr_inc;
          end
        end
      end
      S_AFTER: begin
        if (op == OP_FREE || n_zero) begin
          ptr_next   = b;
          cnt_next   = len;
          state_next = S_REL;
        end else if (len == '0) begin
          state_next = S_ALLOC;
        end else if (!n_big && nc <= len) begin
          res_next = addr;
          if (nc < len) begin
            ptr_next   = b_nc;
            cnt_next   = len - nc;
            trim_next  = 1'b1;
            state_next = S_REL;
          end else begin
            state_next = S_OUT;
          end
        end else if (!n_big && grow_end <= {1'b0, pool}) begin
          state_next = S_GROW_RD;
        end else begin
          move_next  = 1'b1;
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (n_zero || n_big) begin
          st_next    = ST_NOROOM;
          state_next = S_OUT;
        end else begin
          state_next = S_FIT_RD;
        end
      end
      S_FIT_RD: begin
        raddr      = '0;
        ptr_next   = '0;
        run_next   = '0;
        state_next = S_FIT;
      end
      S_FIT: begin
        if (ptr >= pool) begin
          st_next    = ST_NOROOM;
          state_next = S_OUT;
        end else if (rdata.taken) begin
          run_next = '0;
          ptr_next = ptr_inc;
        end else if (run_inc == nc) begin
          ptr_next   = fit_start;
          cnt_next   = nc;
          prod_next  = PW'(fit_start) * PW'(BLOCK_BYTES);
          state_next = S_TAKE;
        end else begin
          run_next = run_inc;
          ptr_next = ptr_inc;
        end
      end
      S_TAKE: begin
        mem_we          = 1'b1;
        mem_wdata.taken = 1'b1;
        mem_wdata.first = (cnt == nc);
        mem_wdata.next  = (cnt != CW'(1));
        ptr_next        = ptr_inc;
        cnt_next        = cnt - 1'b1;
        used_next       = used + 1'b1;
        free_next       = free - 1'b1;
        if (cnt == CW'(1)) begin
          res_next = heap_base + 64'(prod);
          if (move) begin
            moved_next = 1'b1;
            ptr_next   = b;
            cnt_next   = len;
            state_next = S_REL;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_REL: begin
        if (cnt == '0) begin
          state_next = trim ? S_TRIM : S_OUT;
        end else begin
          mem_we    = 1'b1;
          ptr_next  = ptr_inc;
          cnt_next  = cnt - 1'b1;
          used_next = used - 1'b1;
          free_next = free + 1'b1;
        end
      end
      S_TRIM: begin
        mem_we         = 1'b1;
        mem_waddr      = IW'(b_nc - 1'b1);
        mem_wdata      = keep_mark;
        mem_wdata.next = 1'b0;
        state_next     = S_OUT;
      end
      S_GROW_RD: begin
        raddr      = b_len[IW-1:0];
        ptr_next   = b_len;
        state_next = S_GROW;
      end
      S_GROW: begin
        if (ptr == b_nc) begin
          ptr_next   = b_len;
          state_next = S_GROW_WR;
        end else if (rdata.taken) begin
          move_next  = 1'b1;
          state_next = S_ALLOC;
        end else begin
          ptr_next = ptr_inc;
        end
      end
      S_GROW_WR: begin
        mem_we          = 1'b1;
        mem_wdata.taken = 1'b1;
        mem_wdata.next  = (ptr_inc != b_nc);
        ptr_next        = ptr_inc;
        used_next       = used + 1'b1;
        free_next       = free - 1'b1;
        if (ptr_inc == b_nc) begin
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        mem_we         = 1'b1;
        mem_waddr      = IW'(b_len - 1'b1);
        mem_wdata      = last_mark;
        mem_wdata.next = 1'b1;
        res_next       = addr;
        state_next     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // A new pool size empties the table.
    if (cfg_we && cfg_index == CFG_ACTIVE) begin
      state_next = S_CLEAR;
      ptr_next   = '0;
      used_next  = '0;
      free_next  = cfg_pool;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr   <= '0;
      used  <= '0;
      free  <= (NUM_BLOCKS < ACTIVE_RESET) ? CW'(NUM_BLOCKS) : CW'(ACTIVE_RESET);
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      used  <= used_next;
      free  <= free_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    run       <= run_next;
    len       <= len_next;
    b         <= b_next;
    nc        <= nc_next;
    n_zero    <= n_zero_next;
    n_big     <= n_big_next;
    outside   <= outside_next;
    op        <= op_next;
    st        <= st_next;
    addr      <= addr_next;
    res       <= res_next;
    moved     <= moved_next;
    move      <= move_next;
    trim      <= trim_next;
    last_mark <= last_mark_next;
    keep_mark <= keep_mark_next;
    prod      <= prod_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid               <= 1'b1;
      out_data.status         <= st;
      out_data.result_address <= res;
      out_data.moved          <= moved;
      out_data.used_count     <= 11'(used);
      out_data.free_count     <= 11'(free);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> 32'(used) + 32'(free) == 32'(pool))
    else $error("used and free counts do not add up to the pool size");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_CLEAR |-> used <= pool)
    else $error("used count exceeds the pool size");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_we)
    else $error("table written while idle");

  a_accept_index: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !cfg_we |=> state == S_DIVB)
    else $error("accepted request did not move to the block index step");

endmodule
